// ===== src/csv_line_field_splitter_macros.svh =====
// assertion macros for the csv line field splitter checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef CSV_LINE_FIELD_SPLITTER_MACROS_SVH
`define CSV_LINE_FIELD_SPLITTER_MACROS_SVH

// condition implies consequence in the same cycle
`define CSVLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the following cycle
`define CSVLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/csvls_pkg.sv =====
// shared types and constants of the csv line field splitter
// no dependencies
`default_nettype none

package csvls_pkg;

    // field limit and derived saturation point of the field counter
    localparam int MAX_FIELDS  = 64;
    localparam int IDX_W       = 6;
    localparam int FIELD_TOP_I = ((MAX_FIELDS - 1) < 63) ? (MAX_FIELDS - 1) : 63;
    localparam logic [IDX_W-1:0] FIELD_TOP = IDX_W'(FIELD_TOP_I);

    // queue between parser and output sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // result kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // register map, index taken from paddr[2]
    localparam int          PADDR_W   = 3;
    localparam logic        REG_DELIM = 1'b0;
    localparam logic        REG_QUOTE = 1'b1;
    localparam logic [7:0]  DELIM_RST = 8'd44;
    localparam logic [7:0]  QUOTE_RST = 8'd34;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       value;
        logic [IDX_W-1:0] field_index;
        logic             run_last;
        logic             line_done;
    } t_result;

    // one queue entry: the results of one character, one or two
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

    // queue status seen by parser and output sequencer
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } t_qstat;

endpackage

`default_nettype wire

// ===== src/csvls_front.sv =====
// parser front end: quote and delimiter classification, field counting
// depends on csvls_pkg
`default_nettype none

module csvls_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_accept,
    input  wire  [7:0]             i_ch,
    input  wire                    i_line_end,
    input  wire  [7:0]             i_delim,
    input  wire  [7:0]             i_quote,
    output logic                   o_push,
    output csvls_pkg::t_entry      o_entry
);
    import csvls_pkg::*;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_QUOTED  = 2'd1,
        MODE_CLOSED  = 2'd2,
        MODE_DISCARD = 2'd3
    } t_mode;

    t_mode            r_mode, n_mode, mode_after;
    logic [IDX_W-1:0] r_cnt, n_cnt, cnt_after;
    logic             is_quote, is_delim;
    logic             s_put, s_end, s_rej, e_put;
    logic [1:0]       s_kind;
    t_result          s_res, e_res;

    assign is_quote = (i_ch == i_quote);
    assign is_delim = (i_ch == i_delim);

    // per-character mode step
    always_comb begin
        s_put      = 1'b0;
        s_end      = 1'b0;
        s_rej      = 1'b0;
        s_kind     = KIND_CHAR;
        mode_after = r_mode;
        unique case (r_mode)
            MODE_PLAIN: begin
                if (is_quote) begin
                    mode_after = MODE_QUOTED;
                end else if (is_delim) begin
                    s_put  = 1'b1;
                    s_end  = 1'b1;
                    s_kind = KIND_END;
                end else begin
                    s_put = 1'b1;
                end
            end
            MODE_QUOTED: begin
                if (is_quote) begin
                    mode_after = MODE_CLOSED;
                end else begin
                    s_put = 1'b1;
                end
            end
            MODE_CLOSED: begin
                s_put = 1'b1;
                if (is_quote) begin
                    mode_after = MODE_QUOTED;
                end else if (is_delim) begin
                    s_end      = 1'b1;
                    s_kind     = KIND_END;
                    mode_after = MODE_PLAIN;
                end else begin
                    s_rej      = 1'b1;
                    s_kind     = KIND_REJECT;
                    mode_after = MODE_DISCARD;
                end
            end
            MODE_DISCARD: begin
                mode_after = MODE_DISCARD;
            end
            default: begin
                mode_after = MODE_PLAIN;
            end
        endcase
    end

    // field counter after a delimiter, saturating
    assign cnt_after = (s_end && (r_cnt < FIELD_TOP)) ? r_cnt + 1'b1 : r_cnt;

    // line end closes the open field unless the line is being discarded
    assign e_put = i_line_end && (mode_after != MODE_DISCARD);

    // assemble the one or two results of this character
    always_comb begin
        s_res.kind        = s_kind;
        s_res.value       = (s_kind == KIND_CHAR) ? i_ch : 8'd0;
        s_res.field_index = r_cnt;
        s_res.run_last    = !e_put;
        s_res.line_done   = !e_put && (i_line_end || s_rej);

        e_res.kind        = KIND_END;
        e_res.value       = 8'd0;
        e_res.field_index = cnt_after;
        e_res.run_last    = 1'b1;
        e_res.line_done   = 1'b1;

        o_entry.two    = s_put && e_put;
        o_entry.first  = s_put ? s_res : e_res;
        o_entry.second = e_res;
        o_push         = i_accept && (s_put || e_put);
    end

    // next state, back to field zero at line end
    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        if (i_accept) begin
            if (i_line_end) begin
                n_mode = MODE_PLAIN;
                n_cnt  = '0;
            end else begin
                n_mode = mode_after;
                n_cnt  = cnt_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_cnt  <= '0;
        end else begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== src/csvls_queue.sv =====
// short entry queue between parser and output sequencer
// depends on csvls_pkg
`default_nettype none

module csvls_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  csvls_pkg::t_entry      i_entry,
    input  wire                    i_pop,
    output csvls_pkg::t_entry      o_entry,
    output csvls_pkg::t_qstat      o_stat
);
    import csvls_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;
    logic              wr_en, rd_en;

    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.not_full  = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign wr_en = i_push && o_stat.not_full;
    assign rd_en = i_pop && o_stat.not_empty;
    assign o_entry = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + 1'b1;
            if (rd_en) r_rd <= r_rd + 1'b1;
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr] <= i_entry;
    end

endmodule

`default_nettype wire

// ===== src/csvls_back.sv =====
// output sequencer: plays out each queued entry one word per cycle while the output is ready
// depends on csvls_pkg
`default_nettype none

module csvls_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  csvls_pkg::t_entry      i_entry,
    input  csvls_pkg::t_qstat      i_stat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire                    i_ready,
    output csvls_pkg::t_result     o_res
);
    import csvls_pkg::*;

    t_entry r_ent;
    logic   r_valid, r_half;
    logic   take, ent_done;

    assign take     = r_valid && i_ready;
    assign ent_done = take && (!r_ent.two || r_half);
    assign o_pop    = i_stat.not_empty && (!r_valid || ent_done);

    assign o_valid = r_valid;
    assign o_res   = r_half ? r_ent.second : r_ent.first;

    // output word control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_half  <= 1'b0;
            end else if (ent_done) begin
                r_valid <= 1'b0;
                r_half  <= 1'b0;
            end else if (take) begin
                r_half  <= 1'b1;
            end
        end
    end

    // held entry
    always_ff @(posedge i_clk) begin
        if (o_pop) r_ent <= i_entry;
    end

endmodule

`default_nettype wire

// ===== src/csv_line_field_splitter.sv =====
// Splits a CSV line, one character per input word, into field characters,
// field-end marks and line-reject marks. A character is accepted every cycle
// while the four-entry queue between the parser and the output sequencer has
// room; each result is its own output word, so a character that gives two
// results (its own result plus the field end on the line's last character)
// holds the output longer and the queue absorbs the difference. A result is
// registered in the queue and then in the output sequencer before it appears
// on the output. Delimiter and quote bytes sit at APB addresses 0 and 4.
// depends on csvls_pkg, csvls_front, csvls_queue, csvls_back
`default_nettype none

module csv_line_field_splitter (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // apb configuration port
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [csvls_pkg::PADDR_W-1:0]  paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // character input
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire  [7:0]                     i_ch,
    input  wire                            i_line_end,
    // result output
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [1:0]                     o_kind,
    output logic [7:0]                     o_value,
    output logic [csvls_pkg::IDX_W-1:0]    o_field_index,
    output logic                           o_run_last,
    output logic                           o_line_done
);
    import csvls_pkg::*;

    logic [7:0] r_delim, r_quote;
    logic       cfg_wr, in_accept, push, pop;
    t_entry     push_entry, head_entry;
    t_qstat     qstat;
    t_result    res;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RST;
            r_quote <= QUOTE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_DELIM: r_delim <= pwdata[7:0];
                REG_QUOTE: r_quote <= pwdata[7:0];
                default:   r_delim <= r_delim;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            REG_DELIM: prdata = {24'd0, r_delim};
            REG_QUOTE: prdata = {24'd0, r_quote};
            default:   prdata = 32'd0;
        endcase
    end

    // input word handshake
    assign o_ready   = qstat.not_full;
    assign in_accept = i_valid && o_ready;

    csvls_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_ch       (i_ch),
        .i_line_end (i_line_end),
        .i_delim    (r_delim),
        .i_quote    (r_quote),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    csvls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (qstat)
    );

    csvls_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (head_entry),
        .i_stat  (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    // result word fields
    assign o_kind        = res.kind;
    assign o_value       = res.value;
    assign o_field_index = res.field_index;
    assign o_run_last    = res.run_last;
    assign o_line_done   = res.line_done;

endmodule

`default_nettype wire

// ===== src/csvls_checker.sv =====
// port-level checks on the csv line field splitter, bound to the top level
// depends on csvls_pkg and csv_line_field_splitter_macros.svh
`default_nettype none
`include "csv_line_field_splitter_macros.svh"

module csvls_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            o_valid,
    input  wire                            i_ready,
    input  wire  [1:0]                     o_kind,
    input  wire  [7:0]                     o_value,
    input  wire  [csvls_pkg::IDX_W-1:0]    o_field_index,
    input  wire                            o_run_last,
    input  wire                            o_line_done
);
    import csvls_pkg::*;

    logic             stall, non_char, reject, fe_mid;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W+9:0] word;

    // conditions watched on the result port
    assign stall    = o_valid && !i_ready;
    assign non_char = o_valid && (o_kind != KIND_CHAR);
    assign reject   = o_valid && (o_kind == KIND_REJECT);
    assign fe_mid   = o_valid && i_ready && (o_kind == KIND_END) && !o_line_done
                      && (o_field_index != FIELD_TOP);
    assign idx_inc  = o_field_index + 1'b1;
    assign word     = {o_kind, o_value, o_field_index};

    // only field characters carry a value
    `CSVLS_ASSERT_NOW(a_value_zero, non_char, o_value == 8'd0, "value on non-character word")

    // a reject word ends both the character's run and the line
    `CSVLS_ASSERT_NOW(a_reject_ends, reject, o_line_done && o_run_last, "reject flags missing")

    // the line's final word is also the last of its character
    `CSVLS_ASSERT_NOW(a_done_last, o_valid && o_line_done, o_run_last, "done without run last")

    // a stalled result word holds
    `CSVLS_ASSERT_NEXT(a_out_hold, stall, o_valid && $stable(word), "stalled word changed")

    // a field end that does not close the line is followed by the next field or its data
    `CSVLS_ASSERT_NEXT(a_idx_step, fe_mid, !o_valid || o_field_index == $past(idx_inc), "no step")

endmodule

bind csv_line_field_splitter csvls_checker u_csvls_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for csv_line_field_splitter: random and directed csv lines
// against an in-bench tokenizer model, with apb register changes between phases
// depends on csvls_pkg and the csv_line_field_splitter rtl
module tb_top;
    import csvls_pkg::*;

    localparam int IDLE_PCT     = 17;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 1000;
    localparam int PRINT_MAX    = 40;

    localparam logic [PADDR_W-1:0] ADDR_DELIM = {REG_DELIM, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_QUOTE = {REG_QUOTE, 2'b00};

    typedef enum logic [1:0] {
        SCAN_PLAIN   = 2'd0,
        SCAN_QUOTED  = 2'd1,
        SCAN_CLOSED  = 2'd2,
        SCAN_DISCARD = 2'd3
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       le;
    } t_char_word;

    // clock, reset and block ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [7:0]           i_ch = 8'd0;
    logic                 i_line_end = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [1:0]           o_kind;
    logic [7:0]           o_value;
    logic [IDX_W-1:0]     o_field_index;
    logic                 o_run_last;
    logic                 o_line_done;

    // tokenizer model state and configuration
    t_scan_mode           scan_mode = SCAN_PLAIN;
    logic [IDX_W-1:0]     field_cnt = '0;
    logic [7:0]           delim_q = DELIM_RST;
    logic [7:0]           quote_q = QUOTE_RST;

    t_char_word           char_q[$];
    t_result              token_q[$];
    t_result              step_q[$];
    logic [7:0]           line_buf[$];

    // bench control
    bit                   steady = 1'b0;
    bit                   hold_trig = 1'b0;
    bit                   hold_seen = 1'b0;
    int                   hold_left = 0;
    bit                   in_fire_q = 1'b0;
    int                   quiet_cycles = 0;
    int                   mismatches = 0;
    int                   queued_chars = 0;
    int                   chars_in = 0;
    int                   tokens_out = 0;
    int                   rejects_out = 0;
    int                   settings_used = 0;
    t_char_word           next_word;

    csv_line_field_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_ch          (i_ch),
        .i_line_end    (i_line_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_field_index (o_field_index),
        .o_run_last    (o_run_last),
        .o_line_done   (o_line_done)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // one expected token of the current character
    function automatic void emit(input logic [1:0] k, input logic [7:0] v);
        t_result r;
        r.kind        = k;
        r.value       = (k == KIND_CHAR) ? v : 8'd0;
        r.field_index = field_cnt;
        r.run_last    = 1'b0;
        r.line_done   = 1'b0;
        step_q.push_back(r);
    endfunction

    // field end mark, then move to the next field with saturation
    function automatic void close_field();
        emit(KIND_END, 8'd0);
        if (field_cnt < FIELD_TOP)
            field_cnt = field_cnt + 1'b1;
    endfunction

    // expected tokens of one accepted character word
    function automatic void tokenize_char(input logic [7:0] c, input logic le);
        logic    rejected;
        t_result r;
        rejected = 1'b0;
        step_q.delete();
        case (scan_mode)
            SCAN_PLAIN: begin
                if (c == quote_q)
                    scan_mode = SCAN_QUOTED;
                else if (c == delim_q)
                    close_field();
                else
                    emit(KIND_CHAR, c);
            end
            SCAN_QUOTED: begin
                if (c == quote_q)
                    scan_mode = SCAN_CLOSED;
                else
                    emit(KIND_CHAR, c);
            end
            SCAN_CLOSED: begin
                if (c == quote_q) begin
                    emit(KIND_CHAR, c);
                    scan_mode = SCAN_QUOTED;
                end else if (c == delim_q) begin
                    close_field();
                    scan_mode = SCAN_PLAIN;
                end else begin
                    emit(KIND_REJECT, 8'd0);
                    rejected  = 1'b1;
                    scan_mode = SCAN_DISCARD;
                end
            end
            default: ;
        endcase
        // line end closes whatever field is open unless the line was thrown away
        if (le) begin
            if (scan_mode != SCAN_DISCARD)
                emit(KIND_END, 8'd0);
            scan_mode = SCAN_PLAIN;
            field_cnt = '0;
        end
        if (step_q.size() != 0) begin
            r = step_q.pop_back();
            r.run_last = 1'b1;
            if (le || rejected)
                r.line_done = 1'b1;
            step_q.push_back(r);
        end
        foreach (step_q[i])
            token_q.push_back(step_q[i]);
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatches < PRINT_MAX)
            $display("mismatch at %0t, token %0d: %s", $time, tokens_out, msg);
        mismatches++;
    endtask

    // any byte that is neither delimiter nor quote
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == delim_q || b == quote_q);
        return b;
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic le);
        t_char_word w;
        w.ch = c;
        w.le = le;
        char_q.push_back(w);
        queued_chars++;
    endfunction

    // send the buffered line, line end on its last byte
    function automatic void flush_line();
        if (line_buf.size() == 0)
            line_buf.push_back(plain_byte());
        foreach (line_buf[i])
            push_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endfunction

    // well formed line: empty, plain and quoted fields
    function automatic void good_line(input int nf);
        int n;
        for (int f = 0; f < nf; f++) begin
            if (f > 0)
                line_buf.push_back(delim_q);
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    n = $urandom_range(1, 4);
                    repeat (n) line_buf.push_back(plain_byte());
                end
                default: begin
                    line_buf.push_back(quote_q);
                    n = $urandom_range(0, 4);
                    repeat (n) begin
                        case ($urandom_range(0, 3))
                            0: line_buf.push_back(delim_q);
                            1: begin
                                line_buf.push_back(quote_q);
                                line_buf.push_back(quote_q);
                            end
                            default: line_buf.push_back(plain_byte());
                        endcase
                    end
                    // now and then the last quoted field is left open
                    if (f != nf - 1 || $urandom_range(0, 7) != 0)
                        line_buf.push_back(quote_q);
                end
            endcase
        end
        flush_line();
    endfunction

    // quoted field followed by a stray byte, then junk to line end
    function automatic void broken_line();
        int n;
        if ($urandom_range(0, 1)) begin
            line_buf.push_back(plain_byte());
            line_buf.push_back(delim_q);
        end
        line_buf.push_back(quote_q);
        n = $urandom_range(0, 3);
        repeat (n) line_buf.push_back(plain_byte());
        line_buf.push_back(quote_q);
        line_buf.push_back(plain_byte());
        n = $urandom_range(0, 4);
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
        flush_line();
    endfunction

    // raw random bytes with random line ends
    function automatic void noise_run();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            push_char(8'($urandom_range(0, 255)), i == n - 1 || $urandom_range(0, 4) == 0);
    endfunction

    // more fields than the counter can index
    function automatic void wide_line();
        repeat (68) line_buf.push_back(delim_q);
        line_buf.push_back(plain_byte());
        flush_line();
    endfunction

    function automatic void random_lines(input int target);
        int start;
        int r;
        start = queued_chars;
        while (queued_chars - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                good_line($urandom_range(1, 6));
            else if (r < 85)
                broken_line();
            else
                noise_run();
        end
    endfunction

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [7:0] val);
        logic [31:0] hi;
        hi = $urandom();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {hi[31:8], val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DELIM)
            delim_q = val;
        else
            quote_q = val;
    endtask

    task automatic set_chars(input logic [7:0] d, input logic [7:0] q);
        write_reg(ADDR_DELIM, d);
        write_reg(ADDR_QUOTE, q);
        settings_used++;
    endtask

    // sender stays quiet until every queued word is out and every token is back
    task automatic drain();
        while (char_q.size() != 0 || i_valid || token_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // character word driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire_q) begin
            if (char_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_word = char_q.pop_front();
                i_valid    <= 1'b1;
                i_ch       <= next_word.ch;
                i_line_end <= next_word.le;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // token receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // predict on accepted character words, check accepted token words
    always @(posedge i_clk) begin
        t_result want;
        in_fire_q = i_rst_n && i_valid && o_ready;
        if (in_fire_q) begin
            tokenize_char(i_ch, i_line_end);
            chars_in++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (token_q.size() == 0) begin
                note_mismatch("token with none expected");
            end else begin
                want = token_q.pop_front();
                if (want.kind == KIND_REJECT)
                    rejects_out++;
                if (o_kind !== want.kind)
                    note_mismatch($sformatf("kind %0d, want %0d", o_kind, want.kind));
                if (o_value !== want.value)
                    note_mismatch($sformatf("value %0h, want %0h", o_value, want.value));
                if (o_field_index !== want.field_index)
                    note_mismatch($sformatf("field_index %0d, want %0d",
                        o_field_index, want.field_index));
                if (o_run_last !== want.run_last)
                    note_mismatch($sformatf("run_last %0b, want %0b",
                        o_run_last, want.run_last));
                if (o_line_done !== want.line_done)
                    note_mismatch($sformatf("line_done %0b, want %0b",
                        o_line_done, want.line_done));
            end
            tokens_out++;
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus phases
    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed lines under the reset characters
        line_buf = '{8'h00, delim_q, 8'hFF};
        flush_line();
        line_buf = '{quote_q, "x", delim_q, quote_q, quote_q, "y", quote_q};
        flush_line();
        line_buf = '{"a", delim_q};
        flush_line();
        line_buf = '{quote_q, "a", quote_q, "b", delim_q, "c"};
        flush_line();
        line_buf = '{"a", quote_q, "b"};
        flush_line();
        random_lines(80);
        wide_line();
        // receiver stalls while the sender keeps offering
        hold_trig = ~hold_trig;
        drain();

        // extreme characters, no idling on either side
        set_chars(8'h00, 8'hFF);
        steady = 1'b1;
        random_lines(80);
        drain();
        steady = 1'b0;

        set_chars(8'hFF, 8'h00);
        random_lines(80);
        wide_line();
        drain();

        // delimiter equal to quote
        set_chars(8'h22, 8'h22);
        line_buf = '{"a", quote_q, quote_q, "b", quote_q};
        flush_line();
        random_lines(60);
        drain();

        set_chars(8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)));
        random_lines(60);
        drain();

        set_chars(DELIM_RST, QUOTE_RST);
        random_lines(60);
        drain();

        if (token_q.size() != 0)
            note_mismatch($sformatf("%0d tokens never arrived", token_q.size()));
        $display("run covered %0d characters and %0d tokens (%0d line rejects)",
            chars_in, tokens_out, rejects_out);
        $display("under %0d written delimiter and quote settings plus the reset pair",
            settings_used);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
